### rtl/lmol_pkg.sv
// ----------------------------------------------------------------------------
// lmol_pkg
// Shared widths, command codes, controller states and the control/status
// bundles of the latency memory with owner lock.
// ----------------------------------------------------------------------------
package lmol_pkg;

   localparam int ADDR_W   = 32;
   localparam int DATA_W   = 32;
   localparam int CMD_W    = 2;
   localparam int CALLER_W = 3;
   localparam int DELAY_W  = 10;
   localparam int OFFSET_W = 2;

   localparam int WORDS_IN_LINE_DEF = 4;
   localparam int LINE_COUNT_DEF    = 256;

   // address bits reduced per cycle by the serial remainder unit
   localparam int MOD_STEP_BITS = 4;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD   = 2'd0,
      CMD_STORE  = 2'd1,
      CMD_FETCH  = 2'd2,
      CMD_DIRECT = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECIDE,
      ST_READ
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic take_req;
      logic lock_apply;
      logic mem_write;
      logic rsp_wait;
      logic rsp_echo;
      logic rsp_word;
      logic rd_first;
      logic rd_next;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    idx_valid;
      logic    grant;
      logic    rsp_free;
      logic    clear_last;
      logic    word_last;
   } ctrl_sts_type;

endpackage

### rtl/lmol_ifs.sv
// ----------------------------------------------------------------------------
// lmol request and response channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface lmol_req_if
   import lmol_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [ADDR_W-1:0]   address;
   logic [DATA_W-1:0]   write_data;
   logic [CALLER_W-1:0] requester_id;

   modport source (output valid, command, address, write_data, requester_id, input ready);
   modport sink   (input valid, command, address, write_data, requester_id, output ready);
endinterface

interface lmol_rsp_if
   import lmol_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                done_res;
   logic [DATA_W-1:0]   read_data;
   logic [OFFSET_W-1:0] word_offset;
   logic                last;

   modport source (output valid, done_res, read_data, word_offset, last, input ready);
   modport sink   (input valid, done_res, read_data, word_offset, last, output ready);
endinterface

### rtl/lmol_addr_mod.sv
// ----------------------------------------------------------------------------
// lmol_addr_mod
// Reduces a word address to its store index (address mod store depth) and
// its offset within the line (address mod words per line).
// ----------------------------------------------------------------------------
module lmol_addr_mod
   import lmol_pkg::*;
#(
   parameter int WORDS_IN_LINE = WORDS_IN_LINE_DEF,
   parameter int LINE_COUNT    = LINE_COUNT_DEF,
   localparam int DEPTH = WORDS_IN_LINE * LINE_COUNT,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int OFF_W = (WORDS_IN_LINE > 1) ? $clog2(WORDS_IN_LINE) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [ADDR_W-1:0] address,
   output logic              idx_valid,
   output logic [IDX_W-1:0]  idx,
   output logic [OFF_W-1:0]  off
);

   localparam bit IS_POW2 = ((DEPTH & (DEPTH - 1)) == 0);

   if (IS_POW2) begin : g_mask
      logic             valid_ff;
      logic [IDX_W-1:0] idx_ff;
      logic [OFF_W-1:0] off_ff;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (start) begin
            valid_ff <= 1'b1;
         end
      end

      // power-of-two geometry: both remainders are masks
      always_ff @(posedge clock) begin
         if (start) begin
            idx_ff <= IDX_W'(address % DEPTH);
            off_ff <= OFF_W'(address % WORDS_IN_LINE);
         end
      end

      assign idx_valid = valid_ff;
      assign idx       = idx_ff;
      assign off       = off_ff;
   end else begin : g_serial
      localparam int STEPS = ADDR_W / MOD_STEP_BITS;
      localparam int CNT_W = $clog2(STEPS + 1);
      localparam logic [IDX_W:0] MOD_D = (IDX_W + 1)'(DEPTH);
      localparam logic [OFF_W:0] MOD_W = (OFF_W + 1)'(WORDS_IN_LINE);

      logic [ADDR_W-1:0] sh_ff;
      logic [IDX_W-1:0]  rd_ff;
      logic [IDX_W-1:0]  rd_in;
      logic [OFF_W-1:0]  rw_ff;
      logic [OFF_W-1:0]  rw_in;
      logic [CNT_W-1:0]  left_ff;
      logic [IDX_W:0]    td;
      logic [OFF_W:0]    tw;

      // restoring remainder, most significant address bits first
      always_comb begin
         rd_in = rd_ff;
         rw_in = rw_ff;
         td    = '0;
         tw    = '0;
         for (int b = 0; b < MOD_STEP_BITS; b++) begin
            td = {rd_in, sh_ff[ADDR_W-1-b]};
            if (td >= MOD_D) begin
               td = td - MOD_D;
            end
            rd_in = td[IDX_W-1:0];
            tw = {rw_in, sh_ff[ADDR_W-1-b]};
            if (tw >= MOD_W) begin
               tw = tw - MOD_W;
            end
            rw_in = tw[OFF_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            left_ff <= '0;
         end else if (start) begin
            left_ff <= CNT_W'(STEPS);
         end else if (left_ff != '0) begin
            left_ff <= left_ff - 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (start) begin
            sh_ff <= address;
            rd_ff <= '0;
            rw_ff <= '0;
         end else if (left_ff != '0) begin
            sh_ff <= sh_ff << MOD_STEP_BITS;
            rd_ff <= rd_in;
            rw_ff <= rw_in;
         end
      end

      assign idx_valid = (left_ff == '0);
      assign idx       = rd_ff;
      assign off       = rw_ff;
   end

endmodule

### rtl/lmol_datapath.sv
// ----------------------------------------------------------------------------
// lmol_datapath
// Request registers, ownership lock, word store with its clearing pass, line
// fetch sequencing and the response register.
// ----------------------------------------------------------------------------
module lmol_datapath
   import lmol_pkg::*;
#(
   parameter int WORDS_IN_LINE = WORDS_IN_LINE_DEF,
   parameter int LINE_COUNT    = LINE_COUNT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        ctl_cmd,
   output ctrl_sts_type        ctl_sts,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [ADDR_W-1:0]   req_address,
   input  logic [DATA_W-1:0]   req_write_data,
   input  logic [CALLER_W-1:0] req_requester_id,
   input  logic                csr_write_en,
   input  logic [DELAY_W-1:0]  csr_write_data,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic                rsp_done_res,
   output logic [DATA_W-1:0]   rsp_read_data,
   output logic [OFFSET_W-1:0] rsp_word_offset,
   output logic                rsp_last
);

   localparam int DEPTH = WORDS_IN_LINE * LINE_COUNT;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OFF_W = (WORDS_IN_LINE > 1) ? $clog2(WORDS_IN_LINE) : 1;

   cmd_type             cmd_ff;
   logic [DATA_W-1:0]   data_ff;
   logic [CALLER_W-1:0] caller_ff;

   logic                busy_ff, busy_in;
   logic [CALLER_W-1:0] owner_ff, owner_in;
   logic [DELAY_W-1:0]  countdown_ff, countdown_in;
   logic [DELAY_W-1:0]  delay_ff, delay_in;
   logic                mismatch;
   logic                grant;

   logic                idx_valid;
   logic [IDX_W-1:0]    idx;
   logic [OFF_W-1:0]    off;
   logic [IDX_W-1:0]    base;

   logic [IDX_W-1:0]    clr_cnt_ff;
   logic [OFF_W-1:0]    word_cnt_ff;
   logic                word_last;

   logic [DATA_W-1:0]   word_store [DEPTH];
   logic                mem_we;
   logic [IDX_W-1:0]    mem_wa;
   logic [DATA_W-1:0]   mem_wd;
   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic [DATA_W-1:0]   ram_q_ff;

   logic                rsp_free;
   logic                rsp_load;
   logic                rsp_valid_ff;
   logic                done_ff, done_in;
   logic [DATA_W-1:0]   rdata_ff, rdata_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic                last_ff, last_in;

   lmol_addr_mod #(
      .WORDS_IN_LINE (WORDS_IN_LINE),
      .LINE_COUNT    (LINE_COUNT)
   ) u_addr_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (ctl_cmd.take_req),
      .address   (req_address),
      .idx_valid (idx_valid),
      .idx       (idx),
      .off       (off)
   );

   // hold the request for the whole of its handling
   always_ff @(posedge clock) begin
      if (ctl_cmd.take_req) begin
         cmd_ff    <= cmd_type'(req_command);
         data_ff   <= req_write_data;
         caller_ff <= req_requester_id;
      end
   end

   // ownership lock
   assign mismatch = busy_ff && (caller_ff != owner_ff);
   assign grant    = !mismatch && (countdown_ff == '0);

   always_comb begin
      busy_in      = busy_ff;
      owner_in     = owner_ff;
      countdown_in = countdown_ff;
      delay_in     = delay_ff;
      if (ctl_cmd.lock_apply && !mismatch) begin
         if (countdown_ff != '0) begin
            countdown_in = countdown_ff - 1'b1;
            busy_in      = 1'b1;
            owner_in     = caller_ff;
         end else begin
            countdown_in = delay_ff;
            busy_in      = 1'b0;
            owner_in     = '0;
         end
      end
      if (csr_write_en) begin
         delay_in     = csr_write_data;
         countdown_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         owner_ff     <= '0;
         countdown_ff <= '0;
         delay_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         owner_ff     <= owner_in;
         countdown_ff <= countdown_in;
         delay_ff     <= delay_in;
      end
   end

   // clearing pass and line fetch counters
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (ctl_cmd.clear_step) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_cnt_ff <= '0;
      end else if (ctl_cmd.rd_first) begin
         word_cnt_ff <= '0;
      end else if (ctl_cmd.rd_next) begin
         word_cnt_ff <= word_cnt_ff + 1'b1;
      end
   end

   assign word_last = (word_cnt_ff == OFF_W'(WORDS_IN_LINE - 1));
   assign base      = idx - IDX_W'(off);

   // word store: one write port, one registered read port
   assign mem_we = ctl_cmd.clear_step || ctl_cmd.mem_write;
   assign mem_wa = ctl_cmd.clear_step ? clr_cnt_ff : idx;
   assign mem_wd = ctl_cmd.clear_step ? '0 : data_ff;
   assign rd_en  = ctl_cmd.rd_first || ctl_cmd.rd_next;

   always_comb begin
      if (ctl_cmd.rd_next) begin
         rd_addr = base + IDX_W'(word_cnt_ff) + IDX_W'(1);
      end else if (cmd_ff == CMD_FETCH) begin
         rd_addr = base;
      end else begin
         rd_addr = idx;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         word_store[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         ram_q_ff <= word_store[rd_addr];
      end
   end

   // response register
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp_load = ctl_cmd.rsp_wait || ctl_cmd.rsp_echo || ctl_cmd.rsp_word;

   always_comb begin
      done_in   = 1'b0;
      rdata_in  = '0;
      offset_in = '0;
      last_in   = 1'b1;
      if (ctl_cmd.rsp_echo) begin
         done_in   = 1'b1;
         rdata_in  = data_ff;
         offset_in = OFFSET_W'(off);
      end else if (ctl_cmd.rsp_word) begin
         done_in  = 1'b1;
         rdata_in = ram_q_ff;
         if (cmd_ff == CMD_FETCH) begin
            offset_in = OFFSET_W'(word_cnt_ff);
            last_in   = word_last;
         end else begin
            offset_in = OFFSET_W'(off);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         done_ff   <= done_in;
         rdata_ff  <= rdata_in;
         offset_ff <= offset_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_done_res    = done_ff;
   assign rsp_read_data   = rdata_ff;
   assign rsp_word_offset = offset_ff;
   assign rsp_last        = last_ff;

   always_comb begin
      ctl_sts.cmd        = cmd_ff;
      ctl_sts.idx_valid  = idx_valid;
      ctl_sts.grant      = grant;
      ctl_sts.rsp_free   = rsp_free;
      ctl_sts.clear_last = (clr_cnt_ff == IDX_W'(DEPTH - 1));
      ctl_sts.word_last  = word_last;
   end

   a_owner_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (owner_ff == '0))
      else $error("owner set while memory not locked");

   a_grant_release: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.lock_apply && grant |=> !busy_ff)
      else $error("lock still held after a completed access");

   a_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> rsp_free)
      else $error("response register overwritten before transfer");

endmodule

### rtl/lmol_ctrl.sv
// ----------------------------------------------------------------------------
// lmol_ctrl
// Sequencer: clearing pass, request intake, lock decision and word read-out.
// ----------------------------------------------------------------------------
module lmol_ctrl
   import lmol_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ctrl_sts_type ctl_sts,
   output ctrl_cmd_type ctl_cmd
);

   state_type state_ff, state_in;
   logic      decide_go;
   logic      is_direct;

   assign decide_go = ctl_sts.idx_valid && ctl_sts.rsp_free;
   assign is_direct = (ctl_sts.cmd == CMD_DIRECT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (ctl_sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (decide_go) begin
               if (!is_direct && ctl_sts.grant &&
                   (ctl_sts.cmd == CMD_LOAD || ctl_sts.cmd == CMD_FETCH)) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_READ: begin
            if (ctl_sts.rsp_free &&
                (ctl_sts.cmd != CMD_FETCH || ctl_sts.word_last)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl_cmd   = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ctl_cmd.clear_step = 1'b1;
         end
         ST_IDLE: begin
            req_ready        = 1'b1;
            ctl_cmd.take_req = req_valid;
         end
         ST_DECIDE: begin
            if (decide_go) begin
               if (is_direct) begin
                  ctl_cmd.mem_write = 1'b1;
                  ctl_cmd.rsp_echo  = 1'b1;
               end else begin
                  ctl_cmd.lock_apply = 1'b1;
                  if (!ctl_sts.grant) begin
                     ctl_cmd.rsp_wait = 1'b1;
                  end else if (ctl_sts.cmd == CMD_STORE) begin
                     ctl_cmd.mem_write = 1'b1;
                     ctl_cmd.rsp_echo  = 1'b1;
                  end else begin
                     ctl_cmd.rd_first = 1'b1;
                  end
               end
            end
         end
         ST_READ: begin
            if (ctl_sts.rsp_free) begin
               ctl_cmd.rsp_word = 1'b1;
               ctl_cmd.rd_next  = (ctl_sts.cmd == CMD_FETCH) && !ctl_sts.word_last;
            end
         end
         default: ctl_cmd = '0;
      endcase
   end

   a_read_cmd: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> (ctl_sts.cmd == CMD_LOAD || ctl_sts.cmd == CMD_FETCH))
      else $error("read-out entered for a command that reads nothing");

   a_next_in_line: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.rd_next |-> !ctl_sts.word_last)
      else $error("line read-out advanced past the last word");

   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $countones({ctl_cmd.rsp_wait, ctl_cmd.rsp_echo, ctl_cmd.rsp_word}) <= 1)
      else $error("more than one response source selected");

endmodule

### rtl/latency_memory_with_owner_lock.sv
// Flow: the sequencer takes one request at a time; a line fetch returns one word per
//   cycle while the response register is free. A store depth that is not a power of
//   two adds a serial address reduction to each request.
// Reset: synchronous; a clearing pass then zeroes the store.
// ----------------------------------------------------------------------------
// latency_memory_with_owner_lock
// Main memory model with a caller ownership lock and a programmable access
// delay, built as a sequencer and a datapath.
// ----------------------------------------------------------------------------
module latency_memory_with_owner_lock
   import lmol_pkg::*;
#(
   parameter int WORDS_IN_LINE = WORDS_IN_LINE_DEF,
   parameter int LINE_COUNT    = LINE_COUNT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   lmol_req_if.sink           req_chan,
   lmol_rsp_if.source         rsp_chan,
   input  logic               csr_write_en,
   input  logic [DELAY_W-1:0] csr_write_data
);

   // Command and status bundles between sequencer and datapath
   ctrl_cmd_type ctl_cmd;
   ctrl_sts_type ctl_sts;

   // Sequencer: after the clearing pass it takes one request at a time. A
   // request is taken even while the previous response still waits in the
   // response register; the lock decision then holds until that transfer
   // frees the register.
   lmol_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .ctl_sts   (ctl_sts),
      .ctl_cmd   (ctl_cmd)
   );

   // Datapath: the lock (busy, owner, countdown, access delay) is consulted
   // once per request. A caller other than the owner is told to wait with
   // no change; the owner counts the delay down and waits, and at zero the
   // lock drops, the countdown reloads and the access goes ahead. A direct
   // store bypasses the lock entirely. The store index is the address
   // wrapped to the store depth, which equals the line wrap plus the word
   // offset.
   lmol_datapath #(
      .WORDS_IN_LINE (WORDS_IN_LINE),
      .LINE_COUNT    (LINE_COUNT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctl_cmd          (ctl_cmd),
      .ctl_sts          (ctl_sts),
      .req_command      (req_chan.command),
      .req_address      (req_chan.address),
      .req_write_data   (req_chan.write_data),
      .req_requester_id (req_chan.requester_id),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_done_res     (rsp_chan.done_res),
      .rsp_read_data    (rsp_chan.read_data),
      .rsp_word_offset  (rsp_chan.word_offset),
      .rsp_last         (rsp_chan.last)
   );

endmodule

### tb/latency_memory_with_owner_lock_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latency_memory_with_owner_lock_tb
// Self-checking bench for the owner-locked memory model. Requests are driven
// on the valid/ready request channel and each one is run through a local
// predictor of the memory, lock and countdown at the moment it is accepted.
// A checker compares every response transfer with the oldest awaited one.
// ----------------------------------------------------------------------------
module latency_memory_with_owner_lock_tb
   import lmol_pkg::*;
();

   localparam int WORDS       = WORDS_IN_LINE_DEF;
   localparam int LINES       = LINE_COUNT_DEF;
   localparam int SLOTS       = WORDS * LINES;
   localparam int SLOT_BITS   = $clog2(SLOTS);
   // The clearing pass after reset is the longest silent spell on the channels.
   localparam int STALL_LIMIT = 5000;

   typedef struct packed {
      logic                done_res;
      logic [DATA_W-1:0]   read_data;
      logic [OFFSET_W-1:0] word_offset;
      logic                last;
   } mem_rsp_type;

   logic               clock;
   logic               reset;
   logic               csr_write_en;
   logic [DELAY_W-1:0] csr_write_data;

   lmol_req_if req_if ();
   lmol_rsp_if rsp_if ();

   latency_memory_with_owner_lock dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_if),
      .rsp_chan       (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // Local copy of the memory and its lock.
   logic [DATA_W-1:0]   mem_words [SLOTS];
   bit                  lock_busy;
   logic [CALLER_W-1:0] lock_owner;
   logic [DELAY_W-1:0]  lock_countdown;
   logic [DELAY_W-1:0]  access_delay_reg;

   mem_rsp_type       awaited_rsps [$];
   logic [ADDR_W-1:0] written_addrs [$];

   bit granted_now;
   bit steady_traffic;
   int sent_items;
   int mismatch_count;
   int stall_cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(string what);
      mismatch_count++;
      $display("%0t: mismatch: %s", $time, what);
   endtask

   // Apply one accepted request to the local memory; queue the responses it
   // causes and return whether the access went ahead.
   function automatic bit predict_access(cmd_type cmd, logic [ADDR_W-1:0] addr,
                                         logic [DATA_W-1:0] data,
                                         logic [CALLER_W-1:0] caller);
      int unsigned line_no;
      int unsigned off;
      int unsigned slot;
      bit          granted;
      line_no = (addr / WORDS) % LINES;
      off     = addr % WORDS;
      slot    = line_no * WORDS + off;

      // direct store: bypass the lock entirely
      if (cmd == CMD_DIRECT) begin
         mem_words[slot] = data;
         awaited_rsps.push_back('{1'b1, data, OFFSET_W'(off), 1'b1});
         return 1'b1;
      end

      if (!lock_busy) begin
         lock_busy  = 1'b1;
         lock_owner = caller;
      end
      granted = 1'b0;
      if (caller == lock_owner) begin
         if (lock_countdown != '0) begin
            lock_countdown--;
         end else begin
            lock_countdown = access_delay_reg;
            lock_busy      = 1'b0;
            lock_owner     = '0;
            granted        = 1'b1;
         end
      end
      if (!granted) begin
         awaited_rsps.push_back('{1'b0, '0, '0, 1'b1});
         return 1'b0;
      end

      case (cmd)
         CMD_LOAD: begin
            awaited_rsps.push_back('{1'b1, mem_words[slot], OFFSET_W'(off), 1'b1});
         end
         CMD_STORE: begin
            mem_words[slot] = data;
            awaited_rsps.push_back('{1'b1, data, OFFSET_W'(off), 1'b1});
         end
         default: begin
            for (int w = 0; w < WORDS; w++)
               awaited_rsps.push_back('{1'b1, mem_words[line_no * WORDS + w],
                                        OFFSET_W'(w), w == WORDS - 1});
         end
      endcase
      return 1'b1;
   endfunction

   // Half the time reuse a written word under a fresh alias in the upper bits, so
   // that loads and fetches see stored data and the line index wraps.
   function automatic logic [ADDR_W-1:0] pick_address();
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] alias_bits;
      alias_bits = $urandom;
      if (written_addrs.size() == 0 || $urandom_range(1) == 0)
         return $urandom;
      base = written_addrs[$urandom_range(written_addrs.size() - 1)];
      return {alias_bits[ADDR_W-1:SLOT_BITS], base[SLOT_BITS-1:0]};
   endfunction

   // Drive one request, hold it until the transfer and predict its effect.
   task automatic send_request(cmd_type cmd, logic [ADDR_W-1:0] addr,
                               logic [DATA_W-1:0] data, logic [CALLER_W-1:0] caller);
      @(negedge clock);
      if (!steady_traffic && $urandom_range(99) < 11) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.command      <= cmd;
      req_if.address      <= addr;
      req_if.write_data   <= data;
      req_if.requester_id <= caller;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      granted_now = predict_access(cmd, addr, data, caller);
      sent_items++;
      if (cmd == CMD_STORE || cmd == CMD_DIRECT) begin
         written_addrs.push_back(addr);
         if (written_addrs.size() > 16)
            void'(written_addrs.pop_front());
      end
   endtask

   // Drop valid and hold until every awaited response has arrived.
   task automatic wait_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (awaited_rsps.size() != 0) @(posedge clock);
   endtask

   task automatic set_delay(logic [DELAY_W-1:0] value);
      wait_drained();
      // let the sequencer finish its last step before touching the register
      repeat (4) @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en     <= 1'b0;
      access_delay_reg  = value;
      lock_countdown    = value;
   endtask

   // Poll as one caller until its access goes ahead. Any lock held by another
   // caller is run out first by its owner; while the caller owns the lock,
   // other callers cut in now and then if cut_in is set.
   task automatic poll_until_granted(cmd_type cmd, logic [ADDR_W-1:0] addr,
                                     logic [DATA_W-1:0] data,
                                     logic [CALLER_W-1:0] caller, bit cut_in);
      logic [CALLER_W-1:0] other;
      while (lock_busy && lock_owner != caller)
         send_request(CMD_LOAD, pick_address(), $urandom, lock_owner);
      do begin
         if (cut_in && lock_busy && lock_owner == caller && $urandom_range(99) < 25) begin
            other = caller ^ CALLER_W'($urandom_range(1, 7));
            send_request(cmd_type'($urandom_range(3)), pick_address(), $urandom, other);
         end
         send_request(cmd, addr, data, caller);
      end while (!granted_now);
   endtask

   // No delay: every command at the extremes of address, data and caller.
   task automatic test_commands_at_reset();
      send_request(CMD_LOAD,   32'h0000_0000, 32'h0000_0000, 3'd0);
      send_request(CMD_FETCH,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
      send_request(CMD_STORE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
      // line index wraps: this lands on word 0 of line 0
      send_request(CMD_STORE,  32'h0000_0400, 32'hA5A5_A5A5, 3'd1);
      send_request(CMD_LOAD,   32'h0000_0000, 32'h0000_0000, 3'd2);
      send_request(CMD_DIRECT, 32'h8000_0002, 32'h1234_5678, 3'd6);
      send_request(CMD_DIRECT, 32'h0000_0003, 32'hFFFF_FFFF, 3'd3);
      send_request(CMD_FETCH,  32'h0000_0001, 32'h5A5A_5A5A, 3'd4);
      send_request(CMD_LOAD,   32'h0000_03FF, 32'h0000_0000, 3'd5);
      send_request(CMD_FETCH,  32'h7FFF_FFFC, 32'h0000_0000, 3'd0);
   endtask

   // Delay of two: owner waits, other callers are turned away, direct stores
   // go straight through and the lock is released on completion.
   task automatic test_owner_lock();
      set_delay(10'd2);
      send_request(CMD_STORE,  32'h0000_0010, 32'hD1D1_D1D1, 3'd3);
      send_request(CMD_LOAD,   32'h0000_0010, 32'h0000_0000, 3'd5);
      send_request(CMD_DIRECT, 32'h0000_0011, 32'hD2D2_D2D2, 3'd5);
      // caller 0 is not the owner even though a free lock reads as owner 0
      send_request(CMD_FETCH,  32'h0000_0010, 32'h0000_0000, 3'd0);
      send_request(CMD_STORE,  32'h0000_0010, 32'hD1D1_D1D1, 3'd3);
      send_request(CMD_STORE,  32'h0000_0010, 32'hD1D1_D1D1, 3'd3);
      send_request(CMD_FETCH,  32'h0000_0012, 32'h0000_0000, 3'd0);
      send_request(CMD_FETCH,  32'h0000_0012, 32'h0000_0000, 3'd0);
      send_request(CMD_FETCH,  32'h0000_0012, 32'h0000_0000, 3'd0);
   endtask

   // Largest delay, then the smallest non-zero one, then back to none.
   task automatic test_delay_extremes();
      set_delay(10'd1023);
      // a few polls only: the owner counts down from the top of the range
      repeat (4) send_request(CMD_STORE, 32'hC000_0021, 32'h0BAD_F00D, 3'd2);
      send_request(CMD_LOAD,   32'h0000_0021, 32'h0000_0000, 3'd6);
      send_request(CMD_DIRECT, 32'h0000_0022, 32'h0BAD_F00D, 3'd6);
      // rewriting the delay reloads the countdown of the lock still held
      set_delay(10'd1);
      poll_until_granted(CMD_STORE, 32'hC000_0021, 32'h0BAD_F00D, 3'd2, 1'b1);
      poll_until_granted(CMD_LOAD, 32'h0000_0021, $urandom, 3'd6, 1'b0);
      poll_until_granted(CMD_FETCH, 32'h0000_0020, $urandom, 3'd7, 1'b1);
      set_delay(10'd0);
      poll_until_granted(CMD_LOAD, 32'h0000_0021, $urandom, 3'd1, 1'b1);
   endtask

   // Mostly complete polling sequences; some direct stores and lone stray
   // requests that may leave the lock held by a caller who never returns.
   task automatic run_random_phase(int n_items, bit no_gaps);
      int      stop_at;
      int      half_way;
      bit      paused;
      int      pick;
      cmd_type cmd;
      stop_at        = sent_items + n_items;
      half_way       = sent_items + n_items / 2;
      paused         = 1'b0;
      steady_traffic = no_gaps;
      while (sent_items < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            send_request(cmd_type'($urandom_range(3)), $urandom, $urandom,
                         CALLER_W'($urandom_range(7)));
         end else if (pick < 18) begin
            send_request(CMD_DIRECT, pick_address(), $urandom, CALLER_W'($urandom_range(7)));
         end else begin
            cmd = cmd_type'($urandom_range(2));
            poll_until_granted(cmd, pick_address(), $urandom, CALLER_W'($urandom_range(7)),
                               1'b1);
         end
         if (!paused && sent_items >= half_way) begin
            wait_drained();
            paused = 1'b1;
         end
      end
      steady_traffic = 1'b0;
   endtask

   task automatic test_random_traffic();
      set_delay(10'd0);
      run_random_phase(36, 1'b1);
      set_delay(DELAY_W'($urandom_range(1, 6)));
      run_random_phase(36, 1'b0);
      set_delay(10'd3);
      run_random_phase(36, 1'b0);
      set_delay(10'd0);
      run_random_phase(36, 1'b0);
   endtask

   // Response ready: idle now and then, except through the steady stretch.
   always @(negedge clock) begin
      rsp_if.ready <= steady_traffic || ($urandom_range(99) >= 11);
   end

   always @(posedge clock) begin : check_rsp
      mem_rsp_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (awaited_rsps.size() == 0) begin
            report_mismatch("response transfer with nothing awaited");
         end else begin
            want = awaited_rsps.pop_front();
            if (rsp_if.done_res !== want.done_res)
               report_mismatch($sformatf("done_res %b, expected %b",
                                         rsp_if.done_res, want.done_res));
            if (rsp_if.read_data !== want.read_data)
               report_mismatch($sformatf("read_data %h, expected %h",
                                         rsp_if.read_data, want.read_data));
            if (rsp_if.word_offset !== want.word_offset)
               report_mismatch($sformatf("word_offset %0d, expected %0d",
                                         rsp_if.word_offset, want.word_offset));
            if (rsp_if.last !== want.last)
               report_mismatch($sformatf("last %b, expected %b", rsp_if.last, want.last));
         end
      end
   end

   // Watchdog: count cycles with no transfer on either channel.
   always @(posedge clock) begin
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset               = 1'b1;
      csr_write_en        = 1'b0;
      csr_write_data      = '0;
      req_if.valid        = 1'b0;
      req_if.command      = CMD_LOAD;
      req_if.address      = '0;
      req_if.write_data   = '0;
      req_if.requester_id = '0;
      rsp_if.ready        = 1'b0;
      steady_traffic      = 1'b0;
      sent_items          = 0;
      mismatch_count      = 0;
      stall_cycles        = 0;
      // memory and lock as they stand after reset
      foreach (mem_words[i]) mem_words[i] = '0;
      lock_busy        = 1'b0;
      lock_owner       = '0;
      lock_countdown   = '0;
      access_delay_reg = '0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_commands_at_reset();
      test_owner_lock();
      test_delay_extremes();
      test_random_traffic();

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
